@@ hw/rtl/dfs_pkg.sv @@
// Frame store flush engine: shared types, opcodes, status codes and panel bytes.
// No dependencies; used by every other file of the block except dfs_if.
`default_nettype none

package dfs_pkg;

   localparam logic [2:0] OP_WRITE_PIXEL = 3'd0;
   localparam logic [2:0] OP_FILL_RECT   = 3'd1;
   localparam logic [2:0] OP_START_INIT  = 3'd2;
   localparam logic [2:0] OP_START_FLUSH = 3'd3;
   localparam logic [2:0] OP_NEXT_BYTE   = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_BUSY  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   localparam logic [1:0] CSR_COLUMN_OFFSET = 2'd0;
   localparam logic [1:0] CSR_ROW_OFFSET    = 2'd1;
   localparam logic [1:0] CSR_ORIENTATION   = 2'd2;

   localparam logic [7:0] CMD_COLUMN_ADDR = 8'h2A;
   localparam logic [7:0] CMD_ROW_ADDR    = 8'h2B;
   localparam logic [7:0] CMD_MEM_WRITE   = 8'h2C;
   localparam logic [7:0] CMD_SLEEP_OUT   = 8'h11;
   localparam logic [7:0] CMD_MADCTL      = 8'h36;
   localparam logic [7:0] CMD_PIXEL_FMT   = 8'h3A;
   localparam logic [7:0] FMT_RGB565      = 8'h55;
   localparam logic [7:0] CMD_INVERT_ON   = 8'h21;
   localparam logic [7:0] CMD_DISPLAY_ON  = 8'h29;

   localparam logic [3:0] INIT_LEN   = 4'd7;
   localparam logic [3:0] HEADER_LEN = 4'd11;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_INIT   = 4'b0010,
      PH_HEADER = 4'b0100,
      PH_PIXELS = 4'b1000
   } phase_type;

   typedef struct packed {
      logic accept;
      logic fill_step;
      logic pix_emit;
   } cmd_type;

   typedef struct packed {
      logic need_fill;
      logic need_read;
      logic fill_last;
   } stat_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] out_byte;
      logic       is_data;
      logic       transfer_last;
      logic [1:0] status;
   } result_type;

   // {is_data, byte}
   function automatic logic [8:0] init_byte(input logic [3:0] idx, input logic [7:0] orient);
      logic [8:0] r;
      case (idx)
         4'd0:    r = {1'b0, CMD_SLEEP_OUT};
         4'd1:    r = {1'b0, CMD_MADCTL};
         4'd2:    r = {1'b1, orient};
         4'd3:    r = {1'b0, CMD_PIXEL_FMT};
         4'd4:    r = {1'b1, FMT_RGB565};
         4'd5:    r = {1'b0, CMD_INVERT_ON};
         default: r = {1'b0, CMD_DISPLAY_ON};
      endcase
      return r;
   endfunction

   function automatic logic [8:0] header_byte(input logic [3:0] idx,
                                              input logic [15:0] xs, input logic [15:0] xe,
                                              input logic [15:0] ys, input logic [15:0] ye);
      logic [8:0] r;
      case (idx)
         4'd0:    r = {1'b0, CMD_COLUMN_ADDR};
         4'd1:    r = {1'b1, xs[15:8]};
         4'd2:    r = {1'b1, xs[7:0]};
         4'd3:    r = {1'b1, xe[15:8]};
         4'd4:    r = {1'b1, xe[7:0]};
         4'd5:    r = {1'b0, CMD_ROW_ADDR};
         4'd6:    r = {1'b1, ys[15:8]};
         4'd7:    r = {1'b1, ys[7:0]};
         4'd8:    r = {1'b1, ye[15:8]};
         4'd9:    r = {1'b1, ye[7:0]};
         default: r = {1'b0, CMD_MEM_WRITE};
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dfs_if.sv @@
// Request and response channel interfaces of the frame store flush engine.
// Depends on nothing; widths follow the request and result fields.
`default_nettype none

interface dfs_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [9:0]  x_pos;
   logic [9:0]  y_pos;
   logic [9:0]  width_px;
   logic [9:0]  height_px;
   logic [15:0] pixel_color;

   modport source (output valid, opcode, x_pos, y_pos, width_px, height_px, pixel_color,
                   input ready);
   modport sink   (input valid, opcode, x_pos, y_pos, width_px, height_px, pixel_color,
                   output ready);
endinterface

interface dfs_rsp_if;
   logic       valid;
   logic       ready;
   logic       byte_valid;
   logic [7:0] out_byte;
   logic       is_data;
   logic       transfer_last;
   logic [1:0] status;

   modport source (output valid, byte_valid, out_byte, is_data, transfer_last, status,
                   input ready);
   modport sink   (input valid, byte_valid, out_byte, is_data, transfer_last, status,
                   output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dfs_ctrl.sv @@
// Controller of the frame store flush engine: transaction handshake and sequencing.
// Depends on dfs_pkg; drives the datapath through dfs_pkg::cmd_type.
`default_nettype none

module dfs_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire dfs_pkg::stat_type stat,
   output dfs_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_FILL = 3'b010,
      S_READ = 3'b100
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;
   logic           load;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.accept    = accept;
   assign cmd.fill_step = (state_ff == S_FILL);
   assign cmd.pix_emit  = (state_ff == S_READ);

   always_comb begin
      state_in = state_ff;
      load     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (stat.need_fill) begin
                  state_in = S_FILL;
               end else if (stat.need_read) begin
                  state_in = S_READ;
               end else begin
                  load = 1'b1;
               end
            end
         end
         S_FILL: begin
            if (stat.fill_last) begin
               state_in = S_IDLE;
               load     = 1'b1;
            end
         end
         S_READ: begin
            state_in = S_IDLE;
            load     = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state not one-hot");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready)
      else $error("request taken during fill or read");

   a_out_free_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("result register occupied during fill or read");

   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (state_ff == S_IDLE) && rsp_valid_ff)
      else $error("pixel read did not complete in one cycle");

endmodule

`default_nettype wire

@@ hw/rtl/dfs_datapath.sv @@
// Datapath of the frame store flush engine: frame store, fill walker, flush counters,
// byte selection and result register. Depends on dfs_pkg; commanded by dfs_ctrl.
`default_nettype none

module dfs_datapath #(
   parameter int SCREEN_WIDTH  = 240,
   parameter int SCREEN_HEIGHT = 240
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [2:0]        opcode,
   input  wire logic [9:0]        x_pos,
   input  wire logic [9:0]        y_pos,
   input  wire logic [9:0]        width_px,
   input  wire logic [9:0]        height_px,
   input  wire logic [15:0]       pixel_color,
   input  wire logic [9:0]        column_offset,
   input  wire logic [9:0]        row_offset,
   input  wire logic [7:0]        orientation_code,
   input  wire dfs_pkg::cmd_type  cmd,
   output dfs_pkg::stat_type      stat,
   output dfs_pkg::result_type    result
);

   localparam int STORE_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
   localparam logic [10:0] SCR_W = 11'(SCREEN_WIDTH);
   localparam logic [10:0] SCR_H = 11'(SCREEN_HEIGHT);
   localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(SCREEN_WIDTH);

   logic [15:0] store [STORE_SIZE];
   logic [15:0] rd_data_ff;

   dfs_pkg::phase_type phase_ff;
   logic [3:0]  hidx_ff;
   logic [9:0]  win_left_ff, win_top_ff, win_w_ff, win_h_ff;
   logic [9:0]  col_ff, row_ff;
   logic        low_ff;
   logic [ADDR_W-1:0] pix_addr_ff, pix_row_ff;

   logic [9:0]  fill_x_ff, fill_x0_ff, fill_y_ff;
   logic [10:0] fill_xe_ff, fill_ye_ff;
   logic [ADDR_W-1:0] fill_addr_ff, fill_row_ff;
   logic [15:0] fill_color_ff;

   dfs_pkg::result_type res_ff, imm_res, pix_res;

   logic        busy, rejected, in_range, fill_any, win_ok;
   logic [10:0] x_end, y_end, clip_xe, clip_ye;
   logic [20:0] lin_addr;
   logic [ADDR_W-1:0] req_addr;
   logic        fill_go, flush_go, pixel_wr;
   logic [10:0] fill_x_next, fill_y_next, col_next, row_next;
   logic        fill_row_end, col_wrap, row_wrap;
   logic [3:0]  hidx_next;
   logic [15:0] xs, xe, ys, ye;
   logic [8:0]  init_sel, hdr_sel;
   logic        mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [15:0] mem_wdata;

   assign busy     = (phase_ff != dfs_pkg::PH_IDLE);
   assign rejected = (opcode <= dfs_pkg::OP_START_FLUSH) && busy;
   assign x_end    = {1'b0, x_pos} + {1'b0, width_px};
   assign y_end    = {1'b0, y_pos} + {1'b0, height_px};
   assign in_range = ({1'b0, x_pos} < SCR_W) && ({1'b0, y_pos} < SCR_H);
   assign fill_any = in_range && (width_px != 10'd0) && (height_px != 10'd0);
   assign win_ok   = (width_px != 10'd0) && (height_px != 10'd0) &&
                     (x_end <= SCR_W) && (y_end <= SCR_H);
   assign clip_xe  = (x_end > SCR_W) ? SCR_W : x_end;
   assign clip_ye  = (y_end > SCR_H) ? SCR_H : y_end;
   assign lin_addr = 21'(y_pos) * 21'(SCREEN_WIDTH) + 21'(x_pos);
   assign req_addr = lin_addr[ADDR_W-1:0];

   assign fill_go  = cmd.accept && !rejected && (opcode == dfs_pkg::OP_FILL_RECT) && fill_any;
   assign flush_go = cmd.accept && !rejected && (opcode == dfs_pkg::OP_START_FLUSH) && win_ok;
   assign pixel_wr = cmd.accept && !rejected && (opcode == dfs_pkg::OP_WRITE_PIXEL) && in_range;

   assign fill_x_next  = {1'b0, fill_x_ff} + 11'd1;
   assign fill_y_next  = {1'b0, fill_y_ff} + 11'd1;
   assign fill_row_end = (fill_x_next >= fill_xe_ff);

   assign stat.need_fill = (opcode == dfs_pkg::OP_FILL_RECT) && !busy && fill_any;
   assign stat.need_read = (opcode == dfs_pkg::OP_NEXT_BYTE) && (phase_ff == dfs_pkg::PH_PIXELS);
   assign stat.fill_last = fill_row_end && (fill_y_next >= fill_ye_ff);

   assign col_next  = {1'b0, col_ff} + 11'd1;
   assign row_next  = {1'b0, row_ff} + 11'd1;
   assign col_wrap  = (col_next >= {1'b0, win_w_ff});
   assign row_wrap  = (row_next >= {1'b0, win_h_ff});
   assign hidx_next = hidx_ff + 4'd1;

   assign xs = 16'(win_left_ff) + 16'(column_offset);
   assign xe = xs + 16'(win_w_ff) - 16'd1;
   assign ys = 16'(win_top_ff) + 16'(row_offset);
   assign ye = ys + 16'(win_h_ff) - 16'd1;
   assign init_sel = dfs_pkg::init_byte(hidx_ff, orientation_code);
   assign hdr_sel  = dfs_pkg::header_byte(hidx_ff, xs, xe, ys, ye);

   always_comb begin
      imm_res = '0;
      if (rejected) begin
         imm_res.status = dfs_pkg::STATUS_BUSY;
      end else begin
         case (opcode)
            dfs_pkg::OP_WRITE_PIXEL: begin
               if (!in_range) imm_res.status = dfs_pkg::STATUS_RANGE;
            end
            dfs_pkg::OP_START_FLUSH: begin
               if (!win_ok) imm_res.status = dfs_pkg::STATUS_RANGE;
            end
            dfs_pkg::OP_NEXT_BYTE: begin
               if (phase_ff == dfs_pkg::PH_INIT) begin
                  imm_res.byte_valid    = 1'b1;
                  imm_res.is_data       = init_sel[8];
                  imm_res.out_byte      = init_sel[7:0];
                  imm_res.transfer_last = (hidx_next >= dfs_pkg::INIT_LEN);
               end else if (phase_ff == dfs_pkg::PH_HEADER) begin
                  imm_res.byte_valid = 1'b1;
                  imm_res.is_data    = hdr_sel[8];
                  imm_res.out_byte   = hdr_sel[7:0];
               end
            end
            default: imm_res = '0;
         endcase
      end
   end

   always_comb begin
      pix_res               = '0;
      pix_res.byte_valid    = 1'b1;
      pix_res.is_data       = 1'b1;
      pix_res.out_byte      = low_ff ? rd_data_ff[7:0] : rd_data_ff[15:8];
      pix_res.transfer_last = low_ff && col_wrap && row_wrap;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && !stat.need_fill && !stat.need_read) begin
         res_ff <= imm_res;
      end else if (cmd.fill_step && stat.fill_last) begin
         res_ff <= '0;
      end else if (cmd.pix_emit) begin
         res_ff <= pix_res;
      end
   end

   assign result = res_ff;

   // frame store: one write port, one registered read port
   assign mem_we    = pixel_wr || cmd.fill_step;
   assign mem_waddr = cmd.fill_step ? fill_addr_ff : req_addr;
   assign mem_wdata = cmd.fill_step ? fill_color_ff : pixel_color;

   always_ff @(posedge clock) begin
      if (mem_we) store[mem_waddr] <= mem_wdata;
      rd_data_ff <= store[pix_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (fill_go) begin
         fill_x_ff     <= x_pos;
         fill_x0_ff    <= x_pos;
         fill_y_ff     <= y_pos;
         fill_xe_ff    <= clip_xe;
         fill_ye_ff    <= clip_ye;
         fill_addr_ff  <= req_addr;
         fill_row_ff   <= req_addr;
         fill_color_ff <= pixel_color;
      end else if (cmd.fill_step) begin
         if (fill_row_end) begin
            fill_x_ff    <= fill_x0_ff;
            fill_y_ff    <= fill_y_next[9:0];
            fill_row_ff  <= fill_row_ff + ROW_STEP;
            fill_addr_ff <= fill_row_ff + ROW_STEP;
         end else begin
            fill_x_ff    <= fill_x_next[9:0];
            fill_addr_ff <= fill_addr_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (flush_go) begin
         pix_addr_ff <= req_addr;
         pix_row_ff  <= req_addr;
      end else if (cmd.pix_emit && low_ff) begin
         if (col_wrap) begin
            pix_row_ff  <= pix_row_ff + ROW_STEP;
            pix_addr_ff <= pix_row_ff + ROW_STEP;
         end else begin
            pix_addr_ff <= pix_addr_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= dfs_pkg::PH_IDLE;
         hidx_ff     <= '0;
         win_left_ff <= '0;
         win_top_ff  <= '0;
         win_w_ff    <= '0;
         win_h_ff    <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         low_ff      <= 1'b0;
      end else begin
         if (cmd.accept && !rejected) begin
            case (opcode)
               dfs_pkg::OP_START_INIT: begin
                  phase_ff <= dfs_pkg::PH_INIT;
                  hidx_ff  <= '0;
               end
               dfs_pkg::OP_START_FLUSH: begin
                  if (win_ok) begin
                     win_left_ff <= x_pos;
                     win_top_ff  <= y_pos;
                     win_w_ff    <= width_px;
                     win_h_ff    <= height_px;
                     col_ff      <= '0;
                     row_ff      <= '0;
                     low_ff      <= 1'b0;
                     hidx_ff     <= '0;
                     phase_ff    <= dfs_pkg::PH_HEADER;
                  end
               end
               dfs_pkg::OP_NEXT_BYTE: begin
                  if (phase_ff == dfs_pkg::PH_INIT) begin
                     if (hidx_next >= dfs_pkg::INIT_LEN) begin
                        hidx_ff  <= '0;
                        phase_ff <= dfs_pkg::PH_IDLE;
                     end else begin
                        hidx_ff <= hidx_next;
                     end
                  end else if (phase_ff == dfs_pkg::PH_HEADER) begin
                     if (hidx_next >= dfs_pkg::HEADER_LEN) begin
                        hidx_ff  <= '0;
                        phase_ff <= dfs_pkg::PH_PIXELS;
                     end else begin
                        hidx_ff <= hidx_next;
                     end
                  end
               end
               default: hidx_ff <= hidx_ff;
            endcase
         end
         if (cmd.pix_emit) begin
            if (!low_ff) begin
               low_ff <= 1'b1;
            end else begin
               low_ff <= 1'b0;
               if (col_wrap) begin
                  col_ff <= '0;
                  if (row_wrap) begin
                     row_ff   <= '0;
                     phase_ff <= dfs_pkg::PH_IDLE;
                  end else begin
                     row_ff <= row_next[9:0];
                  end
               end else begin
                  col_ff <= col_next[9:0];
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/display_frame_store_flush_engine.sv @@
// Top level of the frame store flush engine: register file, controller and datapath.
// Depends on dfs_pkg, dfs_if, dfs_ctrl and dfs_datapath.
//
//   channel  | direction | handshake          | payload
//   req_if   | in        | valid/ready        | opcode, x_pos, y_pos, width_px, height_px, colour
//   rsp_if   | out       | valid/ready        | byte_valid, out_byte, is_data, last, status
//   csr_*    | in        | csr_we, no stall   | csr_index, csr_wdata
//
// Pixel write, init/flush start, init and header bytes: the result register is loaded when the request is taken.
// Pixel byte: goes through the read state and is taken from the registered read port of the frame store.
// Fill: one store write per cycle over the clipped rectangle, then the result register is loaded.
// A request is taken while idle and the result register is empty or being drained.
// Synchronous reset clears control state only; the frame store holds garbage until written.
`default_nettype none

module display_frame_store_flush_engine #(
   parameter int SCREEN_WIDTH  = 240,
   parameter int SCREEN_HEIGHT = 240
) (
   input  wire logic       clock,
   input  wire logic       reset,
   dfs_req_if.sink         req_if,
   dfs_rsp_if.source       rsp_if,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [9:0] csr_wdata
);

   logic [9:0] column_offset_ff;
   logic [9:0] row_offset_ff;
   logic [7:0] orientation_ff;

   dfs_pkg::cmd_type    cmd;
   dfs_pkg::stat_type   stat;
   dfs_pkg::result_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_offset_ff <= '0;
         row_offset_ff    <= '0;
         orientation_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            dfs_pkg::CSR_COLUMN_OFFSET: column_offset_ff <= csr_wdata;
            dfs_pkg::CSR_ROW_OFFSET:    row_offset_ff    <= csr_wdata;
            dfs_pkg::CSR_ORIENTATION:   orientation_ff   <= csr_wdata[7:0];
            default:                    orientation_ff   <= orientation_ff;
         endcase
      end
   end

   dfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dfs_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .opcode           (req_if.opcode),
      .x_pos            (req_if.x_pos),
      .y_pos            (req_if.y_pos),
      .width_px         (req_if.width_px),
      .height_px        (req_if.height_px),
      .pixel_color      (req_if.pixel_color),
      .column_offset    (column_offset_ff),
      .row_offset       (row_offset_ff),
      .orientation_code (orientation_ff),
      .cmd              (cmd),
      .stat             (stat),
      .result           (result)
   );

   assign rsp_if.byte_valid    = result.byte_valid;
   assign rsp_if.out_byte      = result.out_byte;
   assign rsp_if.is_data       = result.is_data;
   assign rsp_if.transfer_last = result.transfer_last;
   assign rsp_if.status        = result.status;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Testbench for display_frame_store_flush_engine: directed table, then random traffic in phases.
// Uses dfs_pkg and the dfs_req_if / dfs_rsp_if interfaces; checks each response field against
// the directed table's expected result or, for random traffic, an in-house prediction.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCREEN_W    = 240;
   localparam int SCREEN_H    = 240;
   localparam int QUIET_LIMIT = 250000;
   localparam int HOLD_OFF    = 400;

   localparam logic [2:0] OP_UNUSED_7 = 3'd7;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [9:0]  x_pos;
      logic [9:0]  y_pos;
      logic [9:0]  width_px;
      logic [9:0]  height_px;
      logic [15:0] pixel_color;
   } dfs_item_type;

   typedef struct packed {
      dfs_item_type        item;
      dfs_pkg::result_type want;
   } dir_row_type;

   localparam dfs_pkg::result_type R_QUIET =
      '{1'b0, 8'h00, 1'b0, 1'b0, dfs_pkg::STATUS_OK};
   localparam dfs_pkg::result_type R_BUSY  =
      '{1'b0, 8'h00, 1'b0, 1'b0, dfs_pkg::STATUS_BUSY};
   localparam dfs_pkg::result_type R_RANGE =
      '{1'b0, 8'h00, 1'b0, 1'b0, dfs_pkg::STATUS_RANGE};

   localparam int N_DIRECTED = 19;
   localparam dir_row_type DIRECTED [N_DIRECTED] = '{
      '{'{dfs_pkg::OP_NEXT_BYTE,   10'd0,    10'd0,    10'd0,    10'd0,    16'h0000}, R_QUIET},
      '{'{dfs_pkg::OP_START_INIT,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000}, R_QUIET},
      '{'{dfs_pkg::OP_WRITE_PIXEL, 10'd0,    10'd0,    10'd0,    10'd0,    16'h1234}, R_BUSY},
      '{'{dfs_pkg::OP_NEXT_BYTE,   10'd0,    10'd0,    10'd0,    10'd0,    16'h0000},
        '{1'b1, dfs_pkg::CMD_SLEEP_OUT, 1'b0, 1'b0, dfs_pkg::STATUS_OK}},
      '{'{dfs_pkg::OP_NEXT_BYTE,   10'd0,    10'd0,    10'd0,    10'd0,    16'h0000},
        '{1'b1, dfs_pkg::CMD_MADCTL, 1'b0, 1'b0, dfs_pkg::STATUS_OK}},
      '{'{dfs_pkg::OP_NEXT_BYTE,   10'd0,    10'd0,    10'd0,    10'd0,    16'h0000},
        '{1'b1, 8'h00, 1'b1, 1'b0, dfs_pkg::STATUS_OK}},
      '{'{dfs_pkg::OP_NEXT_BYTE,   10'd0,    10'd0,    10'd0,    10'd0,    16'h0000},
        '{1'b1, dfs_pkg::CMD_PIXEL_FMT, 1'b0, 1'b0, dfs_pkg::STATUS_OK}},
      '{'{dfs_pkg::OP_NEXT_BYTE,   10'd0,    10'd0,    10'd0,    10'd0,    16'h0000},
        '{1'b1, dfs_pkg::FMT_RGB565, 1'b1, 1'b0, dfs_pkg::STATUS_OK}},
      '{'{dfs_pkg::OP_NEXT_BYTE,   10'd0,    10'd0,    10'd0,    10'd0,    16'h0000},
        '{1'b1, dfs_pkg::CMD_INVERT_ON, 1'b0, 1'b0, dfs_pkg::STATUS_OK}},
      '{'{dfs_pkg::OP_NEXT_BYTE,   10'd0,    10'd0,    10'd0,    10'd0,    16'h0000},
        '{1'b1, dfs_pkg::CMD_DISPLAY_ON, 1'b0, 1'b1, dfs_pkg::STATUS_OK}},
      // whole screen written here, so later flushes never read an unwritten pixel
      '{'{dfs_pkg::OP_FILL_RECT,   10'd0,    10'd0,    10'd1023, 10'd1023, 16'h8421}, R_QUIET},
      '{'{dfs_pkg::OP_WRITE_PIXEL, 10'd1023, 10'd1023, 10'd0,    10'd0,    16'hFFFF}, R_RANGE},
      '{'{dfs_pkg::OP_WRITE_PIXEL, 10'd239,  10'd239,  10'd0,    10'd0,    16'h0000}, R_QUIET},
      '{'{dfs_pkg::OP_WRITE_PIXEL, 10'd0,    10'd0,    10'd0,    10'd0,    16'hFFFF}, R_QUIET},
      '{'{dfs_pkg::OP_FILL_RECT,   10'd230,  10'd236,  10'd20,   10'd10,   16'h5A5A}, R_QUIET},
      '{'{dfs_pkg::OP_FILL_RECT,   10'd5,    10'd5,    10'd0,    10'd5,    16'hC3C3}, R_QUIET},
      '{'{dfs_pkg::OP_START_FLUSH, 10'd10,   10'd10,   10'd0,    10'd4,    16'h0000}, R_RANGE},
      '{'{dfs_pkg::OP_START_FLUSH, 10'd200,  10'd0,    10'd41,   10'd1,    16'h0000}, R_RANGE},
      '{'{OP_UNUSED_7,             10'd1023, 10'd1023, 10'd1023, 10'd1023, 16'hFFFF}, R_QUIET}
   };

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [9:0] csr_wdata;

   dfs_req_if req_if();
   dfs_rsp_if rsp_if();

   display_frame_store_flush_engine #(
      .SCREEN_WIDTH (SCREEN_W),
      .SCREEN_HEIGHT(SCREEN_H)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .rsp_if   (rsp_if),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow of the panel engine
   logic [15:0]        shadow_frame [0:SCREEN_W*SCREEN_H-1];
   dfs_pkg::phase_type pnl_phase   = dfs_pkg::PH_IDLE;
   int                 seq_idx     = 0;
   int                 win_x       = 0;
   int                 win_y       = 0;
   int                 win_w       = 0;
   int                 win_h       = 0;
   int                 col_ct      = 0;
   int                 row_ct      = 0;
   bit                 low_half    = 1'b0;
   logic [9:0]         col_off     = '0;
   logic [9:0]         row_off     = '0;
   logic [7:0]         orient_code = '0;

   dfs_pkg::result_type expected_bytes [$];
   int          mismatches    = 0;
   int          results_seen  = 0;
   int          panel_bytes   = 0;
   int          taken_items   = 0;
   int          flush_starts  = 0;
   int          init_starts   = 0;
   int          fill_count    = 0;
   int          quiet_cycles  = 0;
   int          burst_left    = 0;
   bit          held_off      = 1'b0;

   function automatic dfs_pkg::result_type predict_panel_byte(input dfs_item_type it);
      dfs_pkg::result_type r;
      int          x_end, y_end, i, j;
      logic [15:0] xs, xe, ys, ye, px;
      r = R_QUIET;
      if (it.opcode <= dfs_pkg::OP_START_FLUSH && pnl_phase != dfs_pkg::PH_IDLE) begin
         r.status = dfs_pkg::STATUS_BUSY;
         return r;
      end
      case (it.opcode)
         dfs_pkg::OP_WRITE_PIXEL: begin
            if (int'(it.x_pos) >= SCREEN_W || int'(it.y_pos) >= SCREEN_H)
               r.status = dfs_pkg::STATUS_RANGE;
            else
               shadow_frame[int'(it.y_pos) * SCREEN_W + int'(it.x_pos)] = it.pixel_color;
         end
         dfs_pkg::OP_FILL_RECT: begin
            fill_count++;
            x_end = int'(it.x_pos) + int'(it.width_px);
            y_end = int'(it.y_pos) + int'(it.height_px);
            if (x_end > SCREEN_W) x_end = SCREEN_W;
            if (y_end > SCREEN_H) y_end = SCREEN_H;
            for (j = int'(it.y_pos); j < y_end; j++)
               for (i = int'(it.x_pos); i < x_end; i++)
                  shadow_frame[j * SCREEN_W + i] = it.pixel_color;
         end
         dfs_pkg::OP_START_INIT: begin
            init_starts++;
            pnl_phase = dfs_pkg::PH_INIT;
            seq_idx   = 0;
         end
         dfs_pkg::OP_START_FLUSH: begin
            if (it.width_px == 0 || it.height_px == 0 ||
                int'(it.x_pos) + int'(it.width_px) > SCREEN_W ||
                int'(it.y_pos) + int'(it.height_px) > SCREEN_H) begin
               r.status = dfs_pkg::STATUS_RANGE;
            end else begin
               flush_starts++;
               win_x     = it.x_pos;
               win_y     = it.y_pos;
               win_w     = it.width_px;
               win_h     = it.height_px;
               col_ct    = 0;
               row_ct    = 0;
               low_half  = 1'b0;
               seq_idx   = 0;
               pnl_phase = dfs_pkg::PH_HEADER;
            end
         end
         dfs_pkg::OP_NEXT_BYTE: begin
            if (pnl_phase != dfs_pkg::PH_IDLE) r.byte_valid = 1'b1;
            case (pnl_phase)
               dfs_pkg::PH_INIT: begin
                  case (seq_idx)
                     0:       r.out_byte = dfs_pkg::CMD_SLEEP_OUT;
                     1:       r.out_byte = dfs_pkg::CMD_MADCTL;
                     2:       begin r.out_byte = orient_code; r.is_data = 1'b1; end
                     3:       r.out_byte = dfs_pkg::CMD_PIXEL_FMT;
                     4:       begin r.out_byte = dfs_pkg::FMT_RGB565; r.is_data = 1'b1; end
                     5:       r.out_byte = dfs_pkg::CMD_INVERT_ON;
                     default: r.out_byte = dfs_pkg::CMD_DISPLAY_ON;
                  endcase
                  seq_idx++;
                  if (seq_idx >= dfs_pkg::INIT_LEN) begin
                     r.transfer_last = 1'b1;
                     seq_idx         = 0;
                     pnl_phase       = dfs_pkg::PH_IDLE;
                  end
               end
               dfs_pkg::PH_HEADER: begin
                  xs = 16'(win_x) + 16'(col_off);
                  xe = xs + 16'(win_w) - 16'd1;
                  ys = 16'(win_y) + 16'(row_off);
                  ye = ys + 16'(win_h) - 16'd1;
                  r.is_data = 1'b1;
                  case (seq_idx)
                     0:       begin r.out_byte = dfs_pkg::CMD_COLUMN_ADDR; r.is_data = 1'b0; end
                     1:       r.out_byte = xs[15:8];
                     2:       r.out_byte = xs[7:0];
                     3:       r.out_byte = xe[15:8];
                     4:       r.out_byte = xe[7:0];
                     5:       begin r.out_byte = dfs_pkg::CMD_ROW_ADDR; r.is_data = 1'b0; end
                     6:       r.out_byte = ys[15:8];
                     7:       r.out_byte = ys[7:0];
                     8:       r.out_byte = ye[15:8];
                     9:       r.out_byte = ye[7:0];
                     default: begin r.out_byte = dfs_pkg::CMD_MEM_WRITE; r.is_data = 1'b0; end
                  endcase
                  seq_idx++;
                  if (seq_idx >= dfs_pkg::HEADER_LEN) begin
                     seq_idx   = 0;
                     pnl_phase = dfs_pkg::PH_PIXELS;
                  end
               end
               dfs_pkg::PH_PIXELS: begin
                  px        = shadow_frame[(win_y + row_ct) * SCREEN_W + win_x + col_ct];
                  r.is_data = 1'b1;
                  if (!low_half) begin
                     r.out_byte = px[15:8];
                     low_half   = 1'b1;
                  end else begin
                     r.out_byte = px[7:0];
                     low_half   = 1'b0;
                     col_ct++;
                     if (col_ct >= win_w) begin
                        col_ct = 0;
                        row_ct++;
                        if (row_ct >= win_h) begin
                           row_ct          = 0;
                           r.transfer_last = 1'b1;
                           pnl_phase       = dfs_pkg::PH_IDLE;
                        end
                     end
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic offer_item(input dfs_item_type it, input bit has_want,
                             input dfs_pkg::result_type want);
      int gap;
      dfs_pkg::result_type predicted;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid       <= 1'b1;
      req_if.opcode      <= it.opcode;
      req_if.x_pos       <= it.x_pos;
      req_if.y_pos       <= it.y_pos;
      req_if.width_px    <= it.width_px;
      req_if.height_px   <= it.height_px;
      req_if.pixel_color <= it.pixel_color;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      taken_items++;
      predicted = predict_panel_byte(it);
      expected_bytes.push_back(has_want ? want : predicted);
   endtask

   task automatic send(input dfs_item_type it);
      offer_item(it, 1'b0, R_QUIET);
   endtask

   function automatic dfs_item_type any_fields(input logic [2:0] op);
      dfs_item_type it;
      it.opcode      = op;
      it.x_pos       = 10'($urandom);
      it.y_pos       = 10'($urandom);
      it.width_px    = 10'($urandom);
      it.height_px   = 10'($urandom);
      it.pixel_color = 16'($urandom);
      return it;
   endfunction

   // keep random fills short: a big on-screen area is pushed off the bottom edge
   function automatic dfs_item_type tame_fill(input dfs_item_type it);
      int cw, ch;
      cw = (int'(it.x_pos) >= SCREEN_W) ? 0 : SCREEN_W - int'(it.x_pos);
      ch = (int'(it.y_pos) >= SCREEN_H) ? 0 : SCREEN_H - int'(it.y_pos);
      if (int'(it.width_px) < cw) cw = it.width_px;
      if (int'(it.height_px) < ch) ch = it.height_px;
      if (cw * ch > 4096) it.y_pos = 10'($urandom_range(SCREEN_H, 1023));
      return it;
   endfunction

   function automatic dfs_item_type flush_window();
      dfs_item_type it;
      int sel, w, h;
      it  = any_fields(dfs_pkg::OP_START_FLUSH);
      sel = $urandom_range(0, 99);
      if (sel < 85) begin
         w = (sel < 70) ? $urandom_range(1, 6) : $urandom_range(1, 8);
         h = (sel < 70) ? $urandom_range(1, 6) : $urandom_range(1, 8);
         it.width_px  = 10'(w);
         it.height_px = 10'(h);
         it.x_pos     = 10'((sel < 70) ? $urandom_range(0, SCREEN_W - w) : SCREEN_W - w);
         it.y_pos     = 10'((sel < 70) ? $urandom_range(0, SCREEN_H - h) : SCREEN_H - h);
      end else if (sel < 88) begin
         if ($urandom_range(0, 1) == 0) begin
            it.x_pos = 10'd0;  it.width_px  = 10'(SCREEN_W);
            it.y_pos = 10'($urandom_range(0, SCREEN_H - 1)); it.height_px = 10'd1;
         end else begin
            it.y_pos = 10'd0;  it.height_px = 10'(SCREEN_H);
            it.x_pos = 10'($urandom_range(0, SCREEN_W - 1)); it.width_px  = 10'd1;
         end
      end else if (it.width_px != 0 && it.height_px != 0 &&
                   int'(it.x_pos) + int'(it.width_px) <= SCREEN_W &&
                   int'(it.y_pos) + int'(it.height_px) <= SCREEN_H) begin
         it.width_px = 10'd0;
      end
      return it;
   endfunction

   // start a transfer and pull it to the end, with the odd rejected request in between
   task automatic run_transfer(input dfs_item_type start_item, inout int made);
      send(start_item);
      made++;
      while (pnl_phase != dfs_pkg::PH_IDLE) begin
         if ($urandom_range(0, 19) == 0) begin
            send(any_fields(3'($urandom_range(dfs_pkg::OP_WRITE_PIXEL,
                                              dfs_pkg::OP_START_FLUSH))));
            made++;
         end
         send(any_fields(dfs_pkg::OP_NEXT_BYTE));
         made++;
      end
   endtask

   task automatic run_random_phase(input int target);
      int made, pick;
      dfs_item_type it;
      made = 0;
      while (made < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            it = any_fields(dfs_pkg::OP_WRITE_PIXEL);
            if ($urandom_range(0, 9) < 8) begin
               it.x_pos = 10'($urandom_range(0, SCREEN_W - 1));
               it.y_pos = 10'($urandom_range(0, SCREEN_H - 1));
            end
            send(it);
            made++;
         end else if (pick < 30) begin
            it = any_fields(dfs_pkg::OP_FILL_RECT);
            if ($urandom_range(0, 1) == 0) begin
               it.x_pos     = 10'($urandom_range(0, SCREEN_W - 1));
               it.y_pos     = 10'($urandom_range(0, SCREEN_H - 1));
               it.width_px  = 10'($urandom_range(0, 12));
               it.height_px = 10'($urandom_range(0, 12));
            end
            send(tame_fill(it));
            made++;
         end else if (pick < 65) begin
            run_transfer(flush_window(), made);
         end else if (pick < 78) begin
            run_transfer(any_fields(dfs_pkg::OP_START_INIT), made);
         end else if (pick < 88) begin
            send(any_fields(dfs_pkg::OP_NEXT_BYTE));
            made++;
         end else if (pick < 94) begin
            send(any_fields(3'($urandom_range(dfs_pkg::OP_NEXT_BYTE + 1, OP_UNUSED_7))));
            made++;
         end else begin
            it = any_fields(3'($urandom_range(dfs_pkg::OP_WRITE_PIXEL, dfs_pkg::OP_NEXT_BYTE)));
            if (it.opcode == dfs_pkg::OP_START_FLUSH) it.opcode = dfs_pkg::OP_START_INIT;
            if (it.opcode == dfs_pkg::OP_FILL_RECT) it = tame_fill(it);
            send(it);
            made++;
         end
      end
      while (pnl_phase != dfs_pkg::PH_IDLE) send(any_fields(dfs_pkg::OP_NEXT_BYTE));
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_panel_config(input logic [9:0] col, input logic [9:0] row,
                                   input logic [7:0] orient);
      csr_we    <= 1'b1;
      csr_index <= dfs_pkg::CSR_COLUMN_OFFSET;
      csr_wdata <= col;
      @(posedge clock);
      col_off   = col;
      csr_index <= dfs_pkg::CSR_ROW_OFFSET;
      csr_wdata <= row;
      @(posedge clock);
      row_off   = row;
      csr_index <= dfs_pkg::CSR_ORIENTATION;
      csr_wdata <= {2'b00, orient};
      @(posedge clock);
      orient_code = orient;
      csr_we    <= 1'b0;
   endtask

   // response checker
   always @(posedge clock) begin
      dfs_pkg::result_type got, want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got = '{rsp_if.byte_valid, rsp_if.out_byte, rsp_if.is_data,
                 rsp_if.transfer_last, rsp_if.status};
         results_seen++;
         if (got.byte_valid === 1'b1) panel_bytes++;
         if (expected_bytes.size() == 0) begin
            if (mismatches < 10)
               $display("response %0d with no transaction outstanding", results_seen);
            mismatches++;
         end else begin
            want = expected_bytes.pop_front();
            if (got.byte_valid !== want.byte_valid || got.out_byte !== want.out_byte ||
                got.is_data !== want.is_data || got.transfer_last !== want.transfer_last ||
                got.status !== want.status) begin
               if (mismatches < 10)
                  $display("response %0d: exp valid=%0b byte=%02h data=%0b last=%0b st=%0d,",
                           results_seen, want.byte_valid, want.out_byte, want.is_data,
                           want.transfer_last, want.status,
                           " got valid=%0b byte=%02h data=%0b last=%0b st=%0d",
                           got.byte_valid, got.out_byte, got.is_data, got.transfer_last,
                           got.status);
               mismatches++;
            end
         end
      end
   end

   // receiver stalls; one long hold-off lets the block back up onto its input
   initial begin : rsp_stall_pattern
      int mode, span, k;
      rsp_if.ready <= 1'b0;
      forever begin
         if (!held_off && results_seen >= 300) begin
            held_off = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 64);
         for (k = 0; k < span; k++) begin
            case (mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_if.ready <= k[2];
            endcase
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("no transaction for %0d cycles", QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int k;
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= dfs_pkg::CSR_COLUMN_OFFSET;
      csr_wdata          <= '0;
      req_if.valid       <= 1'b0;
      req_if.opcode      <= dfs_pkg::OP_NEXT_BYTE;
      req_if.x_pos       <= '0;
      req_if.y_pos       <= '0;
      req_if.width_px    <= '0;
      req_if.height_px   <= '0;
      req_if.pixel_color <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < N_DIRECTED; k++)
         offer_item(DIRECTED[k].item, 1'b1, DIRECTED[k].want);
      settle();

      set_panel_config(10'd1023, 10'd1023, 8'hFF);
      run_random_phase(260);
      settle();
      set_panel_config(10'($urandom), 10'($urandom), 8'($urandom));
      run_random_phase(260);
      settle();
      set_panel_config(10'd0, 10'd0, 8'h00);
      run_random_phase(260);
      settle();
      set_panel_config(10'($urandom), 10'($urandom), 8'($urandom));
      run_random_phase(260);
      settle();

      $display("%0d request transactions, %0d responses, %0d panel bytes, %0d fills",
               taken_items, results_seen, panel_bytes, fill_count);
      $display("%0d window flushes and %0d init sequences over 5 offset settings",
               flush_starts, init_starts);
      if (mismatches == 0 && expected_bytes.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
